// ----- sv/bci_pkg.sv -----
// ----------------------------------------------------------------------------
// bci_pkg: shared types and constants for the breakpoint curve interpolator
// Command codes, result status codes, controller states, datapath operations.
// ----------------------------------------------------------------------------
package bci_pkg;

  localparam int unsigned MaxPointsDef = 32;
  localparam int unsigned TimeW        = 32;
  localparam int unsigned PitchW       = 24;
  localparam int unsigned IndexW       = 5;
  localparam int unsigned StatusW      = 2;
  localparam int unsigned ProdW        = TimeW + PitchW;
  localparam int unsigned NumW         = ProdW + 1;
  localparam logic [TimeW-1:0] MatchWindowUs = TimeW'(1000);

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_QUERY  = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_e;

  typedef enum logic [StatusW-1:0] {
    ST_DONE = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_e;

  typedef enum logic [4:0] {
    S_IDLE, S_DISP,
    S_I_RD, S_I_EV, S_I_POST, S_I_SHRD, S_I_SHWR,
    S_R_RD, S_R_EV, S_R_POST, S_R_SHRD, S_R_SHWR,
    S_Q_RD, S_Q_EV, S_Q_RLO, S_Q_LLO, S_Q_CHK, S_Q_LHI,
    S_Q_MUL, S_Q_DINIT, S_Q_DIV, S_Q_FIN,
    S_DONE
  } state_e;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_SCAN_RD, OP_SCAN_EV, OP_INS_HIT,
    OP_SET_FULL, OP_SH_UP_INIT, OP_SH_UP_RD, OP_SH_UP_WR, OP_INS_PUT,
    OP_SET_MISS, OP_SH_DN_INIT, OP_SH_DN_RD, OP_SH_DN_WR, OP_REM_FIN,
    OP_Q_DFLT, OP_Q_RD_LO, OP_Q_LAT_LO, OP_Q_RD_HI, OP_Q_LAT_HI,
    OP_MUL, OP_DIV_INIT, OP_DIV_STEP, OP_Q_FIN
  } dp_op_e;

  typedef struct packed {
    cmd_e cmd;
    logic cnt_zero;
    logic match;
    logic last;
    logic full;
    logic k_gt_pos;
    logic hit;
    logic dn_more;
    logic q_edge;
    logic step;
    logic div_last;
  } dp_status_t;

endpackage

// ----- sv/bci_ctrl.sv -----
// ----------------------------------------------------------------------------
// bci_ctrl: sequencing controller
// Steps the datapath through scan, shift and interpolation for one command.
// ----------------------------------------------------------------------------
module bci_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  output logic                done_o,
  output bci_pkg::dp_op_e     op_o,
  input  bci_pkg::dp_status_t st_i
);

  bci_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bci_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy   = (state_q != bci_pkg::S_IDLE);
  assign done_o = (state_q == bci_pkg::S_DONE);

  always_comb begin
    state_d = state_q;
    op_o    = bci_pkg::OP_NONE;
    case (state_q)
      bci_pkg::S_IDLE: begin
        if (start) begin
          op_o    = bci_pkg::OP_LOAD;
          state_d = bci_pkg::S_DISP;
        end
      end
      bci_pkg::S_DISP: begin
        case (st_i.cmd)
          bci_pkg::CMD_INSERT: state_d = st_i.cnt_zero ? bci_pkg::S_I_POST : bci_pkg::S_I_RD;
          bci_pkg::CMD_REMOVE: state_d = st_i.cnt_zero ? bci_pkg::S_R_POST : bci_pkg::S_R_RD;
          bci_pkg::CMD_QUERY: begin
            if (st_i.cnt_zero) begin
              op_o    = bci_pkg::OP_Q_DFLT;
              state_d = bci_pkg::S_DONE;
            end else begin
              state_d = bci_pkg::S_Q_RD;
            end
          end
          default: state_d = bci_pkg::S_DONE;
        endcase
      end
      // insert / update
      bci_pkg::S_I_RD: begin
        op_o    = bci_pkg::OP_SCAN_RD;
        state_d = bci_pkg::S_I_EV;
      end
      bci_pkg::S_I_EV: begin
        if (st_i.match) begin
          op_o    = bci_pkg::OP_INS_HIT;
          state_d = bci_pkg::S_DONE;
        end else begin
          op_o    = bci_pkg::OP_SCAN_EV;
          state_d = st_i.last ? bci_pkg::S_I_POST : bci_pkg::S_I_RD;
        end
      end
      bci_pkg::S_I_POST: begin
        if (st_i.full) begin
          op_o    = bci_pkg::OP_SET_FULL;
          state_d = bci_pkg::S_DONE;
        end else begin
          op_o    = bci_pkg::OP_SH_UP_INIT;
          state_d = bci_pkg::S_I_SHRD;
        end
      end
      bci_pkg::S_I_SHRD: begin
        if (st_i.k_gt_pos) begin
          op_o    = bci_pkg::OP_SH_UP_RD;
          state_d = bci_pkg::S_I_SHWR;
        end else begin
          op_o    = bci_pkg::OP_INS_PUT;
          state_d = bci_pkg::S_DONE;
        end
      end
      bci_pkg::S_I_SHWR: begin
        op_o    = bci_pkg::OP_SH_UP_WR;
        state_d = bci_pkg::S_I_SHRD;
      end
      // remove
      bci_pkg::S_R_RD: begin
        op_o    = bci_pkg::OP_SCAN_RD;
        state_d = bci_pkg::S_R_EV;
      end
      bci_pkg::S_R_EV: begin
        op_o    = bci_pkg::OP_SCAN_EV;
        state_d = st_i.last ? bci_pkg::S_R_POST : bci_pkg::S_R_RD;
      end
      bci_pkg::S_R_POST: begin
        if (st_i.hit) begin
          op_o    = bci_pkg::OP_SH_DN_INIT;
          state_d = bci_pkg::S_R_SHRD;
        end else begin
          op_o    = bci_pkg::OP_SET_MISS;
          state_d = bci_pkg::S_DONE;
        end
      end
      bci_pkg::S_R_SHRD: begin
        if (st_i.dn_more) begin
          op_o    = bci_pkg::OP_SH_DN_RD;
          state_d = bci_pkg::S_R_SHWR;
        end else begin
          op_o    = bci_pkg::OP_REM_FIN;
          state_d = bci_pkg::S_DONE;
        end
      end
      bci_pkg::S_R_SHWR: begin
        op_o    = bci_pkg::OP_SH_DN_WR;
        state_d = bci_pkg::S_R_SHRD;
      end
      // query
      bci_pkg::S_Q_RD: begin
        op_o    = bci_pkg::OP_SCAN_RD;
        state_d = bci_pkg::S_Q_EV;
      end
      bci_pkg::S_Q_EV: begin
        op_o    = bci_pkg::OP_SCAN_EV;
        state_d = st_i.last ? bci_pkg::S_Q_RLO : bci_pkg::S_Q_RD;
      end
      bci_pkg::S_Q_RLO: begin
        op_o    = bci_pkg::OP_Q_RD_LO;
        state_d = bci_pkg::S_Q_LLO;
      end
      bci_pkg::S_Q_LLO: begin
        op_o    = bci_pkg::OP_Q_LAT_LO;
        state_d = bci_pkg::S_Q_CHK;
      end
      bci_pkg::S_Q_CHK: begin
        if (st_i.q_edge || st_i.step) begin
          state_d = bci_pkg::S_DONE;
        end else begin
          op_o    = bci_pkg::OP_Q_RD_HI;
          state_d = bci_pkg::S_Q_LHI;
        end
      end
      bci_pkg::S_Q_LHI: begin
        op_o    = bci_pkg::OP_Q_LAT_HI;
        state_d = bci_pkg::S_Q_MUL;
      end
      bci_pkg::S_Q_MUL: begin
        op_o    = bci_pkg::OP_MUL;
        state_d = bci_pkg::S_Q_DINIT;
      end
      bci_pkg::S_Q_DINIT: begin
        op_o    = bci_pkg::OP_DIV_INIT;
        state_d = bci_pkg::S_Q_DIV;
      end
      bci_pkg::S_Q_DIV: begin
        op_o = bci_pkg::OP_DIV_STEP;
        if (st_i.div_last) begin
          state_d = bci_pkg::S_Q_FIN;
        end
      end
      bci_pkg::S_Q_FIN: begin
        op_o    = bci_pkg::OP_Q_FIN;
        state_d = bci_pkg::S_DONE;
      end
      bci_pkg::S_DONE: state_d = bci_pkg::S_IDLE;
      default:         state_d = bci_pkg::S_IDLE;
    endcase
  end

endmodule

// ----- sv/bci_dp.sv -----
// ----------------------------------------------------------------------------
// bci_dp: breakpoint table datapath
// Table memories, scan compare, shift moves, multiplier and serial divider.
// ----------------------------------------------------------------------------
module bci_dp #(
  parameter int unsigned MAX_POINTS = bci_pkg::MaxPointsDef
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  bci_pkg::dp_op_e                     op_i,
  output bci_pkg::dp_status_t                 st_o,
  input  logic [1:0]                          cmd_i,
  input  logic [bci_pkg::TimeW-1:0]           time_us_i,
  input  logic [bci_pkg::PitchW-1:0]          pitch_i,
  input  logic [bci_pkg::TimeW-1:0]           tolerance_us_i,
  input  logic [bci_pkg::PitchW-1:0]          default_pitch_i,
  input  logic                                step_mode_we_i,
  input  logic                                step_mode_i,
  output logic [bci_pkg::PitchW-1:0]          result_pitch_o,
  output logic [bci_pkg::IndexW-1:0]          point_index_o,
  output logic [bci_pkg::StatusW-1:0]         status_o
);

  localparam int unsigned IW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int unsigned CW = $clog2(MAX_POINTS + 1);
  localparam int unsigned TW = bci_pkg::TimeW;
  localparam int unsigned PW = bci_pkg::PitchW;
  localparam int unsigned NW = bci_pkg::NumW;
  localparam int unsigned DCW = $clog2(NW);

  // table storage
  logic [TW-1:0] time_mem  [MAX_POINTS];
  logic [PW-1:0] pitch_mem [MAX_POINTS];
  logic          we;
  logic [IW-1:0] waddr, raddr;
  logic [TW-1:0] wtime;
  logic [PW-1:0] wpitch;
  logic [TW-1:0] rd_t_q;
  logic [PW-1:0] rd_p_q;

  always_ff @(posedge clk_i) begin
    if (we) begin
      time_mem[waddr]  <= wtime;
      pitch_mem[waddr] <= wpitch;
    end
    rd_t_q <= time_mem[raddr];
    rd_p_q <= pitch_mem[raddr];
  end

  // control registers
  logic [CW-1:0] cnt_q, k_q, pos_q, bi_q;
  logic          posf_q, hit_q, step_q;
  logic [DCW-1:0] dcnt_q;
  // payload registers
  bci_pkg::cmd_e  cmd_q;
  logic [TW-1:0]  t_q, best_q, t0_q, span_q, rem_q;
  logic [PW-1:0]  p_q, dflt_q, p0_q, dp_q;
  logic           neg_q;
  logic [bci_pkg::ProdW-1:0] prod_q;
  logic [NW-1:0]  qn_q;
  logic [PW-1:0]  res_q;
  logic [IW-1:0]  idx_q;
  bci_pkg::status_e stat_q;

  logic [TW-1:0] t_diff;
  logic [CW-1:0] k_inc, k_dec, pos_dec;
  logic [TW:0]   rem2;
  logic          ge;
  logic [NW-1:0] num;

  assign t_diff  = (rd_t_q >= t_q) ? (rd_t_q - t_q) : (t_q - rd_t_q);
  assign k_inc   = k_q + CW'(1);
  assign k_dec   = k_q - CW'(1);
  assign pos_dec = pos_q - CW'(1);
  assign rem2    = {rem_q, qn_q[NW-1]};
  assign ge      = (rem2 >= {1'b0, span_q});
  assign num     = {1'b0, prod_q} + (neg_q ? (NW'(span_q) - NW'(1)) : NW'(0));

  always_comb begin
    we     = 1'b0;
    waddr  = k_q[IW-1:0];
    wtime  = rd_t_q;
    wpitch = rd_p_q;
    raddr  = k_q[IW-1:0];
    case (op_i)
      bci_pkg::OP_INS_HIT: begin
        we     = 1'b1;
        wtime  = rd_t_q;
        wpitch = p_q;
      end
      bci_pkg::OP_SH_UP_RD: raddr = k_dec[IW-1:0];
      bci_pkg::OP_SH_UP_WR: we = 1'b1;
      bci_pkg::OP_INS_PUT: begin
        we     = 1'b1;
        waddr  = pos_q[IW-1:0];
        wtime  = t_q;
        wpitch = p_q;
      end
      bci_pkg::OP_SH_DN_RD: raddr = k_inc[IW-1:0];
      bci_pkg::OP_SH_DN_WR: we = 1'b1;
      bci_pkg::OP_Q_RD_LO: begin
        if (pos_q == '0) begin
          raddr = '0;
        end else begin
          raddr = pos_dec[IW-1:0];
        end
      end
      bci_pkg::OP_Q_RD_HI: raddr = pos_q[IW-1:0];
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      k_q    <= '0;
      pos_q  <= '0;
      bi_q   <= '0;
      posf_q <= 1'b0;
      hit_q  <= 1'b0;
      step_q <= 1'b0;
      dcnt_q <= '0;
    end else begin
      if (step_mode_we_i) begin
        step_q <= step_mode_i;
      end
      case (op_i)
        bci_pkg::OP_LOAD: begin
          k_q    <= '0;
          pos_q  <= cnt_q;
          posf_q <= 1'b0;
          hit_q  <= 1'b0;
        end
        bci_pkg::OP_SCAN_EV: begin
          if (!posf_q && (rd_t_q > t_q)) begin
            pos_q  <= k_q;
            posf_q <= 1'b1;
          end
          if (t_diff < best_q) begin
            bi_q  <= k_q;
            hit_q <= 1'b1;
          end
          k_q <= k_inc;
        end
        bci_pkg::OP_SH_UP_INIT: k_q <= cnt_q;
        bci_pkg::OP_SH_UP_WR:   k_q <= k_dec;
        bci_pkg::OP_INS_PUT:    cnt_q <= cnt_q + CW'(1);
        bci_pkg::OP_SH_DN_INIT: k_q <= bi_q;
        bci_pkg::OP_SH_DN_WR:   k_q <= k_inc;
        bci_pkg::OP_REM_FIN:    cnt_q <= cnt_q - CW'(1);
        bci_pkg::OP_DIV_INIT:   dcnt_q <= '0;
        bci_pkg::OP_DIV_STEP:   dcnt_q <= dcnt_q + DCW'(1);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (op_i)
      bci_pkg::OP_LOAD: begin
        cmd_q  <= bci_pkg::cmd_e'(cmd_i);
        t_q    <= time_us_i;
        p_q    <= pitch_i;
        best_q <= tolerance_us_i;
        dflt_q <= default_pitch_i;
        res_q  <= '0;
        idx_q  <= '0;
        stat_q <= bci_pkg::ST_DONE;
      end
      bci_pkg::OP_SCAN_EV: begin
        if (t_diff < best_q) begin
          best_q <= t_diff;
        end
      end
      bci_pkg::OP_INS_HIT:  idx_q <= k_q[IW-1:0];
      bci_pkg::OP_INS_PUT:  idx_q <= pos_q[IW-1:0];
      bci_pkg::OP_SET_FULL: stat_q <= bci_pkg::ST_FULL;
      bci_pkg::OP_SET_MISS: stat_q <= bci_pkg::ST_MISS;
      bci_pkg::OP_Q_DFLT:   res_q <= dflt_q;
      bci_pkg::OP_Q_LAT_LO: begin
        t0_q  <= rd_t_q;
        p0_q  <= rd_p_q;
        res_q <= rd_p_q;
      end
      bci_pkg::OP_Q_LAT_HI: begin
        span_q <= rd_t_q - t0_q;
        neg_q  <= (rd_p_q < p0_q);
        dp_q   <= (rd_p_q >= p0_q) ? (rd_p_q - p0_q) : (p0_q - rd_p_q);
        t0_q   <= t_q - t0_q;
      end
      bci_pkg::OP_MUL: prod_q <= t0_q * dp_q;
      bci_pkg::OP_DIV_INIT: begin
        qn_q  <= num;
        rem_q <= '0;
      end
      bci_pkg::OP_DIV_STEP: begin
        rem_q <= ge ? TW'(rem2 - {1'b0, span_q}) : rem2[TW-1:0];
        qn_q  <= {qn_q[NW-2:0], ge};
      end
      bci_pkg::OP_Q_FIN: begin
        res_q <= neg_q ? (p0_q - qn_q[PW-1:0]) : (p0_q + qn_q[PW-1:0]);
      end
      default: ;
    endcase
  end

  logic [IW+bci_pkg::IndexW-1:0] idx_ext;
  assign idx_ext = {{bci_pkg::IndexW{1'b0}}, idx_q};

  assign st_o.cmd      = cmd_q;
  assign st_o.cnt_zero = (cnt_q == '0);
  assign st_o.match    = (t_diff < bci_pkg::MatchWindowUs);
  assign st_o.last     = (k_inc >= cnt_q);
  assign st_o.full     = (cnt_q == CW'(MAX_POINTS));
  assign st_o.k_gt_pos = (k_q > pos_q);
  assign st_o.hit      = hit_q;
  assign st_o.dn_more  = (k_inc < cnt_q);
  assign st_o.q_edge   = (pos_q == '0) || (pos_q == cnt_q);
  assign st_o.step     = step_q;
  assign st_o.div_last = (dcnt_q == DCW'(NW - 1));

  assign result_pitch_o = res_q;
  assign point_index_o  = idx_ext[bci_pkg::IndexW-1:0];
  assign status_o       = stat_q;

endmodule

// ----- sv/breakpoint_curve_interpolator.sv -----
// ----------------------------------------------------------------------------
// breakpoint_curve_interpolator: time-sorted pitch breakpoint table
// Insert/update, remove-nearest and interpolated query over (time, pitch).
// ----------------------------------------------------------------------------
// Usage: raise start with a command while busy is low; exactly one result
// follows, shown for one cycle with done_o high, and it cannot be held off,
// so the receiver must take it in that cycle. Cost per transaction comes
// from the single-port table scan over the stored points and, for
// insert/remove, the shift of stored points that opens or closes a slot.
// An interpolating query adds a 57-step bit-serial divider. A new command
// is taken only after the done cycle, once busy is low again. step_mode
// may only be written while busy is low.
module breakpoint_curve_interpolator #(
  parameter int unsigned MAX_POINTS = bci_pkg::MaxPointsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // command transaction
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    cmd_i,
  input  logic [bci_pkg::TimeW-1:0]     time_us_i,
  input  logic [bci_pkg::PitchW-1:0]    pitch_i,
  input  logic [bci_pkg::TimeW-1:0]     tolerance_us_i,
  input  logic [bci_pkg::PitchW-1:0]    default_pitch_i,
  // configuration
  input  logic                          step_mode_we_i,
  input  logic                          step_mode_i,
  // result strobe
  output logic                          done_o,
  output logic [bci_pkg::PitchW-1:0]    result_pitch_o,
  output logic [bci_pkg::IndexW-1:0]    point_index_o,
  output logic [bci_pkg::StatusW-1:0]   status_o
);

  bci_pkg::dp_op_e     op;
  bci_pkg::dp_status_t st;

  // controller: sequences scans, shifts and the divider
  bci_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .done_o (done_o),
    .op_o   (op),
    .st_i   (st)
  );

  // datapath: table memories and arithmetic
  bci_dp #(
    .MAX_POINTS (MAX_POINTS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .op_i            (op),
    .st_o            (st),
    .cmd_i           (cmd_i),
    .time_us_i       (time_us_i),
    .pitch_i         (pitch_i),
    .tolerance_us_i  (tolerance_us_i),
    .default_pitch_i (default_pitch_i),
    .step_mode_we_i  (step_mode_we_i),
    .step_mode_i     (step_mode_i),
    .result_pitch_o  (result_pitch_o),
    .point_index_o   (point_index_o),
    .status_o        (status_o)
  );

endmodule
